FILE: rtl/manchester_frame_decoder_top_defines.svh
// Assertion helpers for the frame decoder
`ifndef MANCHESTER_FRAME_DECODER_TOP_DEFINES_SVH
`define MANCHESTER_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define MFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mfd_pkg.sv
package mfd_pkg;

    localparam int FRAME_BYTES_DEFAULT = 16;
    localparam int POS_W               = 4;
    localparam int NIB_W               = 4;
    localparam int PAYLOAD_W           = 64;
    localparam int NIBBLES             = PAYLOAD_W / NIB_W;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [NIB_W-1:0] SYM_01_01 = 4'h5;
    localparam logic [NIB_W-1:0] SYM_01_10 = 4'h6;
    localparam logic [NIB_W-1:0] SYM_10_01 = 4'h9;
    localparam logic [NIB_W-1:0] SYM_10_10 = 4'hA;

    localparam logic [NIB_W-1:0] TYPE_METER   = 4'h0;
    localparam logic [NIB_W-1:0] TYPE_PAIR    = 4'h8;
    localparam logic [NIB_W-1:0] TYPE_COUNTER = 4'h4;

    typedef enum logic [1:0] {
        KIND_METER   = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_COUNTER = 2'd2,
        KIND_UNKNOWN = 2'd3
    } frame_kind_t;

    typedef logic [POS_W-1:0] pos_t;

    // one classified byte, front to back
    typedef struct packed {
        logic [NIB_W-1:0] nib;
        logic             legal;
        pos_t             pos;
        logic             last;
    } beat_info_t;

    function automatic logic nibble_legal(input logic [NIB_W-1:0] n);
        logic ok;
        ok = n inside {SYM_01_01, SYM_01_10, SYM_10_01, SYM_10_10};
        return ok;
    endfunction

    function automatic logic [NIB_W-1:0] data_nibble(input logic [7:0] b);
        logic [NIB_W-1:0] d;
        d = {b[7], b[5], b[3], b[1]};
        return d;
    endfunction

endpackage

FILE: rtl/mfd_front.sv
module mfd_front
    import mfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] raw_byte,
    input  logic       frame_start,
    input  logic       q_full,
    output logic       q_push,
    output beat_info_t q_data
);

    localparam pos_t LAST_POS = POS_W'(FRAME_BYTES - 1);

    pos_t pos_reg;
    pos_t pos_next;
    pos_t pos_cur;
    logic accept;
    logic is_last;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign pos_cur  = frame_start ? '0 : pos_reg;
    assign is_last  = (pos_cur == LAST_POS);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = is_last ? '0 : pos_cur + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign q_push       = accept;
    assign q_data.nib   = data_nibble(raw_byte);
    assign q_data.legal = nibble_legal(raw_byte[7:4]) && nibble_legal(raw_byte[3:0]);
    assign q_data.pos   = pos_cur;
    assign q_data.last  = is_last;

endmodule

FILE: rtl/mfd_fifo.sv
module mfd_fifo
    import mfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  beat_info_t push_data,
    input  logic       pop,
    output beat_info_t head,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    beat_info_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mfd_back.sv
`include "manchester_frame_decoder_top_defines.svh"

module mfd_back
    import mfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  beat_info_t  head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_ok,
    output logic [1:0]  frame_kind,
    output logic [11:0] sensor_id,
    output logic        reading_one_present,
    output logic [14:0] reading_one,
    output logic        reading_two_present,
    output logic [14:0] reading_two,
    output logic        reading_three_present,
    output logic [14:0] reading_three,
    output logic [63:0] payload_bits
);

    localparam int DATA_BYTES = (FRAME_BYTES / 2) * 2;

    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;
    logic                 legal_reg;
    logic                 legal_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 frame_ok_reg;
    frame_kind_t          kind_reg;
    logic [11:0]          sensor_id_reg;
    logic                 r1_present_reg;
    logic [14:0]          r1_reg;
    logic                 r2_present_reg;
    logic [14:0]          r2_reg;
    logic                 r3_present_reg;
    logic [14:0]          r3_reg;
    logic [PAYLOAD_W-1:0] payload_bits_reg;

    logic                 out_free;
    logic                 finish;
    logic [PAYLOAD_W-1:0] merged;
    logic                 merged_legal;
    frame_kind_t          kind_c;
    logic                 readings_on;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = !q_empty && (!head.last || out_free);
    assign finish   = q_pop && head.last;

    // position zero opens a fresh frame
    always_comb
    begin
        merged       = (head.pos == '0) ? '0 : payload_reg;
        merged_legal = ((head.pos == '0) ? 1'b1 : legal_reg) && head.legal;
        for (int i = 0; i < NIBBLES; i++)
        begin
            if ((i < DATA_BYTES) && (head.pos == POS_W'(i)))
            begin
                merged[PAYLOAD_W-1-NIB_W*i -: NIB_W] = head.nib;
            end
        end
    end

    always_comb
    begin
        case (merged[63:60])
            TYPE_METER:   kind_c = KIND_METER;
            TYPE_PAIR:    kind_c = KIND_PAIR;
            TYPE_COUNTER: kind_c = KIND_COUNTER;
            default:      kind_c = KIND_UNKNOWN;
        endcase
    end

    assign readings_on = merged_legal && (kind_c == KIND_METER || kind_c == KIND_PAIR);

    always_comb
    begin
        payload_next = payload_reg;
        legal_next   = legal_reg;
        if (q_pop)
        begin
            payload_next = merged;
            legal_next   = merged_legal;
        end
    end

    assign out_valid_next = finish ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_reg   <= '0;
            legal_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            payload_reg   <= payload_next;
            legal_reg     <= legal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            frame_ok_reg     <= merged_legal;
            kind_reg         <= merged_legal ? kind_c : KIND_METER;
            sensor_id_reg    <= merged_legal ? merged[59:48] : '0;
            r1_present_reg   <= readings_on && merged[47];
            r1_reg           <= readings_on ? merged[46:32] : '0;
            r2_present_reg   <= readings_on && merged[31];
            r2_reg           <= readings_on ? merged[30:16] : '0;
            r3_present_reg   <= readings_on && merged[15];
            r3_reg           <= readings_on ? merged[14:0] : '0;
            payload_bits_reg <= merged_legal ? merged : '0;
        end
    end

    assign out_valid             = out_valid_reg;
    assign frame_ok              = frame_ok_reg;
    assign frame_kind            = kind_reg;
    assign sensor_id             = sensor_id_reg;
    assign reading_one_present   = r1_present_reg;
    assign reading_one           = r1_reg;
    assign reading_two_present   = r2_present_reg;
    assign reading_two           = r2_reg;
    assign reading_three_present = r3_present_reg;
    assign reading_three         = r3_reg;
    assign payload_bits          = payload_bits_reg;

    `MFD_ASSERT_NOW(a_bad_frame_blank, out_valid_reg && !frame_ok_reg, payload_bits_reg == '0 && sensor_id_reg == '0 && kind_reg == KIND_METER, "invalid frame carries data")
    `MFD_ASSERT_NOW(a_no_readings, out_valid_reg && (kind_reg == KIND_COUNTER || kind_reg == KIND_UNKNOWN), r1_reg == '0 && r2_reg == '0 && r3_reg == '0 && !r1_present_reg && !r2_present_reg && !r3_present_reg, "readings set for non-meter kind")
    `MFD_ASSERT_NEXT(a_finish_shows, finish, out_valid_reg, "finished frame not presented")

endmodule

FILE: rtl/manchester_frame_decoder_top.sv
// Channel  Handshake              Beat contents
// -------  ---------------------  ------------------------------------------
// in       in_valid / in_stall    raw_byte, frame_start
// out      out_valid / out_stall  frame_ok, frame_kind, sensor_id, readings,
//                                 payload_bits (one beat per frame)
//
// One byte per cycle sustained while in_stall is low; the front classifies each
// byte in the cycle it is taken, a two-deep queue feeds the back end, which merges
// one nibble per cycle, save when a frame's last byte waits on a held result.
// rst_n clears position, payload and validity state at once; no clearing pass.
// out_stall holds the result register; the queue then fills and in_stall rises.
module manchester_frame_decoder_top
    import mfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  raw_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_ok,
    output logic [1:0]  frame_kind,
    output logic [11:0] sensor_id,
    output logic        reading_one_present,
    output logic [14:0] reading_one,
    output logic        reading_two_present,
    output logic [14:0] reading_two,
    output logic        reading_three_present,
    output logic [14:0] reading_three,
    output logic [63:0] payload_bits
);

    beat_info_t push_data;
    beat_info_t head;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;

    mfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_byte    (raw_byte),
        .frame_start (frame_start),
        .q_full      (q_full),
        .q_push      (push),
        .q_data      (push_data)
    );

    mfd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    mfd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .head                  (head),
        .q_empty               (q_empty),
        .q_pop                 (pop),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .frame_ok              (frame_ok),
        .frame_kind            (frame_kind),
        .sensor_id             (sensor_id),
        .reading_one_present   (reading_one_present),
        .reading_one           (reading_one),
        .reading_two_present   (reading_two_present),
        .reading_two           (reading_two),
        .reading_three_present (reading_three_present),
        .reading_three         (reading_three),
        .payload_bits          (payload_bits)
    );

endmodule
